>>> rtl/crc16h_pkg.sv
package crc16h_pkg;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [3:0]  NIBBLE_MASK = 4'hF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in;
	} in_t;

	typedef struct packed {
		logic [6:0] codeword;
		logic       last_out;
	} out_t;

	// which nibble of the request goes out next
	typedef enum logic [2:0] {
		SLOT_DATA_HI,
		SLOT_DATA_LO,
		SLOT_CRCL_HI,
		SLOT_CRCL_LO,
		SLOT_CRCH_HI,
		SLOT_CRCH_LO
	} slot_t;

	// reflected crc-16, one byte folded in
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// hamming(7,4), bits p1 p2 d1 p3 d2 d3 d4 from msb down
	function automatic logic [6:0] ham74(input logic [3:0] nib);
		logic d1;
		logic d2;
		logic d3;
		logic d4;
		d1 = nib[3];
		d2 = nib[2];
		d3 = nib[1];
		d4 = nib[0];
		return {d1 ^ d2 ^ d4, d1 ^ d3 ^ d4, d1, d2 ^ d3 ^ d4, d2, d3, d4};
	endfunction

endpackage

>>> rtl/crc16h_crc.sv
module crc16h_crc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        last_in,
	output logic [15:0] crc_new
);

	logic [15:0] crc_q;

	assign crc_new = crc16h_pkg::crc_fold(crc_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= crc16h_pkg::CRC_INIT;
		end else if (accept) begin
			crc_q <= last_in ? crc16h_pkg::CRC_INIT : crc_new;
		end
	end

	// a packet end restores the seed for the next packet
	a_seed_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_in |=> crc_q == crc16h_pkg::CRC_INIT)
		else $error("crc not restored after last byte");

	// mid-packet bytes carry the running value forward
	a_carry: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_in |=> crc_q == $past(crc_new))
		else $error("crc not carried forward");

	// no request, no change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(crc_q))
		else $error("crc changed without a request");

endmodule

>>> rtl/crc16h_ser.sv
module crc16h_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  crc16h_pkg::in_t    req,
	input  logic [15:0]        crc_new,
	output logic               busy_free,
	output logic               out_valid,
	input  logic               out_ready,
	output crc16h_pkg::out_t   out_data
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic                last_s1;
	logic [15:0]         crc_s1;
	crc16h_pkg::slot_t   slot_q;
	crc16h_pkg::slot_t   slot_next;
	logic [3:0]          nib;
	logic                load_ok;
	logic                emit;
	logic                final_emit;
	logic                out_valid_q;
	crc16h_pkg::out_t    out_q;

	always_comb begin
		unique case (slot_q)
			crc16h_pkg::SLOT_DATA_HI: begin
				nib       = data_s1[7:4];
				slot_next = crc16h_pkg::SLOT_DATA_LO;
			end
			crc16h_pkg::SLOT_DATA_LO: begin
				nib       = data_s1[3:0];
				slot_next = crc16h_pkg::SLOT_CRCL_HI;
			end
			crc16h_pkg::SLOT_CRCL_HI: begin
				nib       = crc_s1[7:4];
				slot_next = crc16h_pkg::SLOT_CRCL_LO;
			end
			crc16h_pkg::SLOT_CRCL_LO: begin
				nib       = crc_s1[3:0];
				slot_next = crc16h_pkg::SLOT_CRCH_HI;
			end
			crc16h_pkg::SLOT_CRCH_HI: begin
				nib       = crc_s1[15:12];
				slot_next = crc16h_pkg::SLOT_CRCH_LO;
			end
			crc16h_pkg::SLOT_CRCH_LO: begin
				nib       = crc_s1[11:8];
				slot_next = crc16h_pkg::SLOT_DATA_HI;
			end
			default: begin
				nib       = 4'h0;
				slot_next = crc16h_pkg::SLOT_DATA_HI;
			end
		endcase
	end

	assign load_ok    = out_ready || !out_valid_q;
	assign emit       = valid_s1 && load_ok;
	assign final_emit = last_s1 ? (slot_q == crc16h_pkg::SLOT_CRCH_LO)
	                            : (slot_q == crc16h_pkg::SLOT_DATA_LO);
	assign busy_free  = !valid_s1 || (emit && final_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			slot_q      <= crc16h_pkg::SLOT_DATA_HI;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (emit && final_emit) begin
				valid_s1 <= 1'b0;
			end
			if (emit) begin
				slot_q <= final_emit ? crc16h_pkg::SLOT_DATA_HI : slot_next;
			end
			if (load_ok) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= req.data_byte;
			last_s1 <= req.last_in;
			crc_s1  <= crc_new;
		end
		if (emit) begin
			out_q.codeword <= crc16h_pkg::ham74(nib & crc16h_pkg::NIBBLE_MASK);
			out_q.last_out <= last_s1 && (slot_q == crc16h_pkg::SLOT_CRCH_LO);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// crc slots only exist for a byte that ends its packet
	a_crc_slot_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && slot_q != crc16h_pkg::SLOT_DATA_HI && slot_q != crc16h_pkg::SLOT_DATA_LO
		|-> last_s1)
		else $error("crc slot reached on a mid-packet byte");

	// an empty stage always waits at the first slot
	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> slot_q == crc16h_pkg::SLOT_DATA_HI)
		else $error("slot counter not rewound");

	// a new request only enters once the held one has gone out in full
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept && valid_s1 |-> emit && final_emit)
		else $error("held request overwritten");

endmodule

>>> rtl/crc16_hamming74_packet_encoder_unit.sv
// channel  | valid     | ready     | payload                        | moves
// ---------+-----------+-----------+--------------------------------+----------------------------
// in       | in_valid  | in_ready  | in_data  (data_byte, last_in)  | one payload byte
// out      | out_valid | out_ready | out_data (codeword, last_out)  | one hamming(7,4) codeword
//
// a byte request yields 2 codewords, a byte with last_in yields 6
// one codeword leaves per cycle while out_ready is high;
// the single output register sets that pace
// a new request is taken in the same cycle the held one sends its final codeword
// reset (arst_n low) empties both stages and seeds the crc with 0xffff
// a stall on out_ready holds the output register and, while a request is
// held, holds in_ready low
module crc16_hamming74_packet_encoder_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crc16h_pkg::in_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output crc16h_pkg::out_t  out_data
);

	logic        accept;
	logic [15:0] crc_new;
	logic        busy_free;

	// request handshake
	assign in_ready = busy_free;
	assign accept   = in_valid && in_ready;

	// running checksum, folded at request time
	crc16h_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (in_data.data_byte),
		.last_in   (in_data.last_in),
		.crc_new   (crc_new)
	);

	// holding stage, nibble sequencer and output register
	crc16h_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (in_data),
		.crc_new   (crc_new),
		.busy_free (busy_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
